@@ rtl/core/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the Hamming SEC codec
// Request payload structs, the operation code and the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    // Fixed field widths
    localparam int unsigned WORD_W = 63;
    localparam int unsigned CFG_W  = 3;

    // Parity bit count: lower clamp, reset value, default ceiling
    localparam int unsigned PARITY_BITS_MIN   = 2;
    localparam int unsigned PARITY_BITS_RESET = 6;
    localparam int unsigned MAX_PARITY_BITS_DFLT = 6;

    // Operation code
    typedef enum logic [0:0] {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } hsc_func_t;

    // Input request
    typedef struct packed {
        hsc_func_t          func;
        logic [WORD_W-1:0]  word;
    } hsc_in_t;

    // Result request
    typedef struct packed {
        logic [WORD_W-1:0]  result_word;
        logic               has_error;
    } hsc_out_t;

endpackage : hsc_pkg

`default_nettype wire

@@ rtl/core/hamming_sec_codec_top.sv @@
// ----------------------------------------------------------------------------
// hamming_sec_codec_top: Hamming single-error-correcting encoder/decoder
// Encodes data into a 2^P-1 bit codeword or corrects and unpacks a received
// codeword, P set by the configuration register.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  --------+------------------------------+-----------------------------------
//  input   | s_valid  s_ready  s_data     | hsc_in_t  {func, word}
//  result  | m_valid  m_ready  m_data     | hsc_out_t {result_word, has_error}
//  config  | cfg_valid cfg_ready cfg_data | n_parity_bits, always ready
//
//  One request per cycle sustained while the result side takes results; a
//  request passes four register stages (capture, scatter/mask, syndrome
//  tree, correct/extract), the last being the output register, where it
//  waits to be taken.
//  Reset (aresetn low, synchronous) empties all stages and sets P to 6.
//  The pipeline advances as a whole whenever the output register is empty
//  or being taken; otherwise every stage holds, so a stall drops nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_codec_top
    import hsc_pkg::*;
#(
    parameter int unsigned MAX_PARITY_BITS = MAX_PARITY_BITS_DFLT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire hsc_in_t           s_data,

    output      logic              m_valid,
    input  wire logic              m_ready,
    output      hsc_out_t          m_data,

    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int unsigned PW   = MAX_PARITY_BITS;
    localparam int unsigned MaxN = (1 << MAX_PARITY_BITS) - 1;

    // Mask of codeword positions 1..2^p-1
    function automatic logic [MaxN-1:0] pos_mask(input logic [CFG_W-1:0] p);
        logic [MaxN-1:0] m;
        m = '0;
        for (int i = 0; i < MaxN; i++) begin
            m[i] = (((i + 1) >> p) == 0);
        end
        return m;
    endfunction

    // Clamp the register value into the supported range
    function automatic logic [CFG_W-1:0] clamp_p(input logic [CFG_W-1:0] p);
        logic [CFG_W-1:0] r;
        if (p < CFG_W'(PARITY_BITS_MIN)) begin
            r = CFG_W'(PARITY_BITS_MIN);
        end else if (p > CFG_W'(MAX_PARITY_BITS)) begin
            r = CFG_W'(MAX_PARITY_BITS);
        end else begin
            r = p;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_p_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_p_reg <= CFG_W'(PARITY_BITS_RESET);
        end else if (cfg_valid && cfg_ready) begin
            cfg_p_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic              adv;

    logic              a_valid_reg;
    hsc_func_t         a_func_reg;
    logic [WORD_W-1:0] a_word_reg;
    logic [CFG_W-1:0]  a_p_reg;

    logic              b_valid_reg;
    hsc_func_t         b_func_reg;
    logic [MaxN-1:0]   b_cw_reg;
    logic [MaxN-1:0]   b_cw_next;
    logic [CFG_W-1:0]  b_p_reg;

    logic              c_valid_reg;
    hsc_func_t         c_func_reg;
    logic [MaxN-1:0]   c_cw_reg;
    logic [CFG_W-1:0]  c_p_reg;
    logic [PW-1:0]     c_syn_reg;
    logic [PW-1:0]     c_syn_next;

    logic              m_valid_reg;
    hsc_out_t          m_data_reg;
    hsc_out_t          m_data_next;

    // Advance everything when the output register frees up
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Scatter data into non-power-of-two positions, or take the codeword
    always_comb begin
        logic [MaxN-1:0] cw;
        int              k;
        cw = '0;
        k  = 0;
        if (a_func_reg == FUNC_ENCODE) begin
            for (int pos = 1; pos <= MaxN; pos++) begin
                if ((pos & (pos - 1)) != 0) begin
                    cw[pos-1] = a_word_reg[k];
                    k++;
                end
            end
        end else begin
            cw = a_word_reg[MaxN-1:0];
        end
        b_cw_next = cw & pos_mask(a_p_reg);
    end

    // Syndrome: XOR of the indices of all set positions
    always_comb begin
        c_syn_next = '0;
        for (int b = 0; b < PW; b++) begin
            for (int i = 0; i < MaxN; i++) begin
                if ((((i + 1) >> b) & 1) != 0) begin
                    c_syn_next[b] = c_syn_next[b] ^ b_cw_reg[i];
                end
            end
        end
    end

    // Finish: insert parity on encode, correct and unpack on decode
    always_comb begin
        logic [MaxN-1:0]   fixed;
        logic [WORD_W-1:0] data;
        int                k;
        fixed = c_cw_reg;
        data  = '0;
        k     = 0;
        m_data_next = '0;
        unique case (c_func_reg)
            FUNC_ENCODE: begin
                for (int b = 0; b < PW; b++) begin
                    fixed[(1 << b) - 1] = c_cw_reg[(1 << b) - 1] | c_syn_reg[b];
                end
                m_data_next.result_word = WORD_W'(fixed);
                m_data_next.has_error   = 1'b0;
            end
            FUNC_DECODE: begin
                for (int i = 0; i < MaxN; i++) begin
                    fixed[i] = c_cw_reg[i] ^ (c_syn_reg == PW'(i + 1));
                end
                for (int pos = 1; pos <= MaxN; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        data[k] = fixed[pos-1];
                        k++;
                    end
                end
                m_data_next.result_word = data;
                m_data_next.has_error   = (c_syn_reg != '0);
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    // Payload stages; hold on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_func_reg <= s_data.func;
            a_word_reg <= s_data.word;
            a_p_reg    <= clamp_p(cfg_p_reg);

            b_func_reg <= a_func_reg;
            b_cw_reg   <= b_cw_next;
            b_p_reg    <= a_p_reg;

            c_func_reg <= b_func_reg;
            c_cw_reg   <= b_cw_reg;
            c_p_reg    <= b_p_reg;
            c_syn_reg  <= c_syn_next;

            m_data_reg <= m_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Masked codeword carries nothing above position 2^p-1
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> ((b_cw_reg & ~pos_mask(b_p_reg)) == '0))
        else $error("codeword bits set above the configured length");

    // Syndrome always names a position inside the codeword
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> ((MaxN'(c_syn_reg) & ~pos_mask(c_p_reg)) == '0))
        else $error("syndrome points outside the codeword");

    // A stalled stage keeps its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && b_valid_reg) |=> (b_valid_reg && $stable(b_cw_reg)))
        else $error("stage lost or changed its request during a stall");

    // Encode results never flag an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && c_valid_reg && c_func_reg == FUNC_ENCODE) |=> !m_data_reg.has_error)
        else $error("encode result flagged an error");

endmodule : hamming_sec_codec_top

`default_nettype wire
